@@ hdl/adeq_pkg.sv @@
// ----------------------------------------------------------------------------
// adeq_pkg: shared definitions for the asymmetric debounce event queue
// Codes, field widths and register reset values used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package adeq_pkg;

  // Default depth of the event queue.
  localparam int QUEUE_DEPTH_DEF = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_RISE_CONFIRM  = 2'd1;
  localparam logic [1:0] CFG_FALL_CONFIRM  = 2'd2;

  // Configuration register reset values.
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd10;
  localparam logic [7:0]  RISE_CONFIRM_RST  = 8'd5;
  localparam logic [7:0]  FALL_CONFIRM_RST  = 8'd20;

  // Operation carried in the sideband of each input beat.
  localparam logic [1:0] MODE_POLL   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_REINIT = 2'd2;

  // Event codes held in the queue and returned on a pop.
  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_ON   = 2'd1,
    EVT_OFF  = 2'd2
  } evt_t;

  localparam int EVT_W = 2;

endpackage

`default_nettype wire

@@ hdl/adeq_ram.sv @@
// ----------------------------------------------------------------------------
// adeq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// its value while no read is issued. A read of the address being written
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module adeq_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/asymmetric_debounce_event_queue_core.sv @@
// ----------------------------------------------------------------------------
// asymmetric_debounce_event_queue_core: magnet switch debouncer with queue
// Samples a raw switch level at a minimum interval, confirms level changes
// after separate rise and fall run lengths and queues on/off events.
//
// Usage:
//   Input channel (in_*): one beat per call. in_tuser carries the mode
//   (poll, poll and pop, reinitialise); in_tdata the timestamp and raw level.
//   Output channel (out_*): exactly one result beat per input beat, in order,
//   with the popped event, the confirmed level, the debouncing flag and the
//   last on-to-off hold time.
//   Configuration port (cfg_*): single-cycle register writes; the user must
//   make them only while the block is idle, which the block does not enforce.
//   A beat accepted at one edge has its result in the output register from
//   that edge. Throughput is one beat per cycle while results are taken;
//   all state is updated by one pass of logic, and a popped event comes from
//   a registered event RAM read in the accept cycle or a bypass register.
//   While the receiver stalls, the pending result holds and the input side
//   takes a new beat only in the cycle the result is taken.
//   Reset restores the default poll interval and confirm counts, clears the
//   debouncer state and empties the queue at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module asymmetric_debounce_event_queue_core #(
  parameter int QUEUE_DEPTH = adeq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // now_ms[31:0], raw_level[32], zero pad
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  // Output channel
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // event_code[1:0], magnet_present[2],
                                       // debouncing[3], hold_time_ms[35:4], pad
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  import adeq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

  // Configuration registers
  logic [15:0] poll_r;
  logic [7:0]  rise_r;
  logic [7:0]  fall_r;

  // Debouncer state
  logic [31:0] last_r,  last_nxt;
  logic [7:0]  cnt_r,   cnt_nxt;
  logic        conf_r,  conf_nxt;
  logic        cand_r,  cand_nxt;
  logic [31:0] rise_t_r, rise_t_nxt;
  logic [31:0] hold_r,  hold_nxt;

  // Queue state
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [FW-1:0] fill_r,   fill_nxt;

  // Output register
  logic       out_valid_r;
  logic       pop_ram_r,  pop_ram_nxt;
  logic [1:0] byp_evt_r,  byp_evt_nxt;

  // Accept-cycle signals
  logic        accept;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic        raw_level;
  logic        is_reinit;
  logic        is_pop;
  logic [31:0] elapsed;
  logic        take;
  logic [7:0]  cnt_inc;
  logic [7:0]  needed;
  logic        confirm;
  logic        push;
  logic [1:0]  push_evt;
  logic [FW-1:0] fill_mid;
  logic        pop_ok;
  logic        bypass;
  logic        ram_re;
  logic [1:0]  ram_rdata;
  logic [1:0]  evt_out;

  assign mode      = in_tuser;
  assign now_ms    = in_tdata[31:0];
  assign raw_level = in_tdata[32];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r <= POLL_INTERVAL_RST;
      rise_r <= RISE_CONFIRM_RST;
      fall_r <= FALL_CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POLL_INTERVAL: poll_r <= cfg_wdata;
        CFG_RISE_CONFIRM:  rise_r <= cfg_wdata[7:0];
        CFG_FALL_CONFIRM:  fall_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Mode decode; the unused code behaves as a plain poll.
  always_comb begin
    is_reinit = 1'b0;
    is_pop    = 1'b0;
    unique case (mode)
      MODE_REINIT: is_reinit = 1'b1;
      MODE_POP:    is_pop    = 1'b1;
      default: ;
    endcase
  end

  // Sample gate and run counter arithmetic.
  assign elapsed = now_ms - last_r;
  assign take    = !is_reinit && (elapsed >= {16'd0, poll_r});
  assign cnt_inc = (cnt_r != 8'hFF) ? cnt_r + 8'd1 : cnt_r;
  assign needed  = raw_level ? rise_r : fall_r;

  // Debouncer next state.
  always_comb begin
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    conf_nxt   = conf_r;
    cand_nxt   = cand_r;
    rise_t_nxt = rise_t_r;
    hold_nxt   = hold_r;
    confirm    = 1'b0;
    if (is_reinit) begin
      conf_nxt   = 1'b0;
      cand_nxt   = raw_level;
      cnt_nxt    = 8'd0;
      last_nxt   = now_ms;
      rise_t_nxt = 32'd0;
    end else if (take) begin
      last_nxt = now_ms;
      if (raw_level == conf_r) begin
        // Bounce back to the confirmed level cancels the run.
        cand_nxt = raw_level;
        cnt_nxt  = 8'd0;
      end else if (raw_level != cand_r) begin
        // First differing sample opens a new run.
        cand_nxt = raw_level;
        cnt_nxt  = 8'd1;
      end else if (cnt_inc >= needed) begin
        confirm  = 1'b1;
        conf_nxt = raw_level;
        cnt_nxt  = 8'd0;
        if (raw_level) begin
          rise_t_nxt = now_ms;
        end else begin
          hold_nxt   = (rise_t_r != 32'd0) ? now_ms - rise_t_r : 32'd0;
          rise_t_nxt = 32'd0;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // Queue control: push before pop, full queue drops the event.
  assign push_evt = raw_level ? EVT_ON : EVT_OFF;
  assign push     = confirm && (fill_r != FILL_MAX);
  assign fill_mid = push ? fill_r + FW'(1) : fill_r;
  assign pop_ok   = is_pop && (fill_mid != '0);
  assign bypass   = pop_ok && (fill_r == '0);
  assign ram_re   = accept && pop_ok && !bypass;

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    fill_nxt    = fill_mid;
    pop_ram_nxt = 1'b0;
    byp_evt_nxt = EVT_NONE;
    if (is_reinit) begin
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      fill_nxt   = '0;
    end else begin
      if (push) begin
        wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + AW'(1);
      end
      if (pop_ok) begin
        rd_idx_nxt = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + AW'(1);
        fill_nxt   = fill_mid - FW'(1);
        // An event pushed into an empty queue by a pop beat is popped straight away.
        if (bypass) begin
          byp_evt_nxt = push_evt;
        end else begin
          pop_ram_nxt = 1'b1;
        end
      end
    end
  end

  // State registers, updated on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 32'd0;
      cnt_r    <= 8'd0;
      conf_r   <= 1'b0;
      cand_r   <= 1'b0;
      rise_t_r <= 32'd0;
      hold_r   <= 32'd0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      fill_r   <= '0;
    end else if (accept) begin
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
      conf_r   <= conf_nxt;
      cand_r   <= cand_nxt;
      rise_t_r <= rise_t_nxt;
      hold_r   <= hold_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Event store.
  adeq_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_evt_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (wr_idx_r),
    .wdata (push_evt),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Output register: valid flag and the source of the popped event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pop_ram_r   <= 1'b0;
      byp_evt_r   <= EVT_NONE;
    end else if (accept) begin
      out_valid_r <= 1'b1;
      pop_ram_r   <= pop_ram_nxt;
      byp_evt_r   <= byp_evt_nxt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result beat; the level and hold fields come from the state registers,
  // which change only together with the output register.
  assign evt_out    = pop_ram_r ? ram_rdata : byp_evt_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, hold_r, (cand_r != conf_r), conf_r, evt_out};

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the asymmetric debounce event queue
// Sends timestamped switch samples with poll, pop and reinitialise modes,
// predicts every result beat with its own copy of the debouncer and event
// queue, and compares each beat field by field. The sender works in bursts
// and the receiver stalls on its own pattern. Directed cases come first,
// then random phases under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import adeq_pkg::*;

  localparam int         DEPTH       = QUEUE_DEPTH_DEF;
  localparam int         PTR_W       = $clog2(DEPTH) + 1;
  localparam int         CYCLE_LIMIT = 400000;
  // The spare mode code is treated as a plain poll.
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct packed {
    evt_t        code;
    logic        present;
    logic        bouncing;
    logic [31:0] hold_ms;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // now_ms[31:0], raw_level[32], zero pad
  logic [1:0]  in_tuser = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // event_code[1:0], magnet_present[2],
                                // debouncing[3], hold_time_ms[35:4], pad
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  asymmetric_debounce_event_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Free-running clock, period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the registers and of the debouncer state.
  logic [15:0]      poll_ms    = POLL_INTERVAL_RST;
  logic [7:0]       rise_cnt   = RISE_CONFIRM_RST;
  logic [7:0]       fall_cnt   = FALL_CONFIRM_RST;
  logic [31:0]      sample_ms  = '0;
  logic [7:0]       run_len    = '0;
  logic             conf_level = 1'b0;
  logic             cand_level = 1'b0;
  evt_t             event_ring [DEPTH];
  logic [PTR_W-1:0] wr_ptr     = '0;
  logic [PTR_W-1:0] rd_ptr     = '0;
  logic [31:0]      on_ms      = '0;
  logic [31:0]      last_hold  = '0;

  status_t     pending_status [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic [31:0] clock_ms = '0;
  logic        drive_level = 1'b0;
  int          run_left = 0;

  // Advance the debouncer by one call and return the status beat it gives.
  function automatic status_t debounce_call(input logic [1:0] mode,
                                            input logic [31:0] now,
                                            input logic raw);
    status_t          res;
    logic [7:0]       needed;
    logic [31:0]      since;
    logic             confirmed;
    logic [PTR_W-1:0] fill;
    confirmed = 1'b0;
    res.code  = EVT_NONE;
    if (mode == MODE_REINIT) begin
      conf_level = 1'b0;
      cand_level = raw;
      run_len    = '0;
      sample_ms  = now;
      wr_ptr     = '0;
      rd_ptr     = '0;
      on_ms      = '0;
    end else begin
      since = now - sample_ms;
      if (since >= {16'd0, poll_ms}) begin
        sample_ms = now;
        if (raw == conf_level) begin
          cand_level = raw;
          run_len    = '0;
        end else if (raw != cand_level) begin
          cand_level = raw;
          run_len    = 8'd1;
        end else begin
          if (run_len != 8'hFF) run_len = run_len + 8'd1;
          needed = raw ? rise_cnt : fall_cnt;
          confirmed = (run_len >= needed);
        end
      end
      // A confirmed change records the timing and queues an event.
      if (confirmed) begin
        conf_level = raw;
        run_len    = '0;
        if (raw) begin
          on_ms = now;
        end else begin
          last_hold = (on_ms != 0) ? now - on_ms : 32'd0;
          on_ms     = '0;
        end
        fill = wr_ptr - rd_ptr;
        if (fill < DEPTH) begin
          event_ring[wr_ptr[PTR_W-2:0]] = raw ? EVT_ON : EVT_OFF;
          wr_ptr = wr_ptr + 1'b1;
        end
      end
      if (mode == MODE_POP && wr_ptr != rd_ptr) begin
        res.code = event_ring[rd_ptr[PTR_W-2:0]];
        rd_ptr   = rd_ptr + 1'b1;
      end
    end
    res.present  = conf_level;
    res.bouncing = (cand_level != conf_level);
    res.hold_ms  = last_hold;
    return res;
  endfunction

  // Send one call, record its expected status, then maybe idle between bursts.
  task automatic send_call(input logic [1:0] mode, input logic [31:0] now,
                           input logic raw);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, raw, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(debounce_call(mode, now, raw));
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every expected beat has been taken.
  task automatic wait_all_reported();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; junk in unused high bits.
  task automatic program_debouncer(input logic [15:0] poll, input logic [7:0] rise,
                                   input logic [7:0] fall);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_POLL_INTERVAL;
    cfg_wdata <= poll;
    @(posedge clk);
    cfg_addr  <= CFG_RISE_CONFIRM;
    cfg_wdata <= {junk, rise};
    @(posedge clk);
    cfg_addr  <= CFG_FALL_CONFIRM;
    cfg_wdata <= {~junk, fall};
    @(posedge clk);
    cfg_we <= 1'b0;
    poll_ms  = poll;
    rise_cnt = rise;
    fall_cnt = fall;
  endtask

  // Random calls: steady level runs with bounces, timestamps mostly past the
  // poll interval, occasional jumps and a mix of pops and reinitialisations.
  task automatic run_sequence(input int n, input int pop_pct);
    int         roll;
    logic [1:0] mode;
    logic       raw;
    logic [7:0] needed;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_all_reported();
      roll = $urandom_range(0, 99);
      if (roll < pop_pct)          mode = MODE_POP;
      else if (roll < pop_pct + 2) mode = MODE_REINIT;
      else if (roll < pop_pct + 5) mode = MODE_SPARE;
      else                         mode = MODE_POLL;
      roll = $urandom_range(0, 99);
      if (roll < 3)       clock_ms = $urandom;
      else if (roll < 18) clock_ms = clock_ms + $urandom_range(0, poll_ms);
      else                clock_ms = clock_ms + poll_ms + $urandom_range(0, 3);
      if (run_left == 0) begin
        drive_level = ~drive_level;
        needed = drive_level ? rise_cnt : fall_cnt;
        run_left = ($urandom_range(0, 3) != 0) ? needed + $urandom_range(1, 4)
                                               : $urandom_range(1, needed);
      end
      run_left--;
      raw = ($urandom_range(0, 99) < 8) ? ~drive_level : drive_level;
      send_call(mode, clock_ms, raw);
    end
  endtask

  // Reset values of the registers: poll interval of ten, start of a rise.
  task automatic test_reset_state();
    send_call(MODE_POP, 32'd0, 1'b0);
    send_call(MODE_POLL, 32'd9, 1'b1);
    send_call(MODE_POLL, 32'd10, 1'b1);
  endtask

  // Short runs that hit the corner cases of confirmation, timing and the queue.
  task automatic test_special_cases();
    wait_all_reported();
    program_debouncer(16'd0, 8'd1, 8'd1);
    send_call(MODE_REINIT, 32'd0, 1'b0);
    send_call(MODE_SPARE, 32'hFFFF_FFFF, 1'b1);
    // Rise confirmed at timestamp zero, so no on time is recorded.
    send_call(MODE_POLL, 32'd0, 1'b1);
    send_call(MODE_POLL, 32'd5, 1'b0);
    // Bounce back to the confirmed level cancels the run.
    send_call(MODE_POLL, 32'd7, 1'b1);
    send_call(MODE_POLL, 32'd8, 1'b0);
    send_call(MODE_POLL, 32'd9, 1'b0);
    // Hold time measured across the timestamp wrap.
    send_call(MODE_POLL, 32'hFFFF_FFF0, 1'b1);
    send_call(MODE_POLL, 32'hFFFF_FFF1, 1'b1);
    send_call(MODE_POLL, 32'h0000_0010, 1'b0);
    send_call(MODE_POP, 32'h0000_0011, 1'b0);
    // Reinitialise with the pin high, then confirm on the first sample.
    send_call(MODE_REINIT, 32'h0000_0020, 1'b1);
    send_call(MODE_POP, 32'h0000_0020, 1'b1);
  endtask

  // Largest poll interval and thresholds: one short of the interval is skipped.
  task automatic test_poll_interval();
    wait_all_reported();
    program_debouncer(16'hFFFF, 8'hFF, 8'hFF);
    send_call(MODE_POLL, 32'h0000_0020 + 32'd65534, 1'b0);
    send_call(MODE_POLL, 32'h0000_0020 + 32'd65535, 1'b0);
    send_call(MODE_POP, 32'h0000_0020 + 32'd131070, 1'b0);
    clock_ms = 32'h0000_0020 + 32'd131070;
  endtask

  // Fast confirmation with rare pops, so the queue fills and drops events.
  task automatic test_queue_overflow();
    wait_all_reported();
    program_debouncer(16'd0, 8'd1, 8'd1);
    run_sequence(150, 5);
  endtask

  task automatic test_default_settings();
    wait_all_reported();
    program_debouncer(POLL_INTERVAL_RST, RISE_CONFIRM_RST, FALL_CONFIRM_RST);
    run_sequence(150, 20);
  endtask

  task automatic test_fast_rise_slow_fall();
    wait_all_reported();
    program_debouncer(16'd4, 8'd1, 8'd255);
    run_sequence(150, 25);
  endtask

  task automatic test_long_runs();
    wait_all_reported();
    program_debouncer(16'd2, 8'd255, 8'd255);
    run_sequence(200, 10);
  endtask

  // Thresholds lowered under a run in progress confirm on the next sample.
  task automatic test_threshold_drop();
    wait_all_reported();
    program_debouncer(16'd1, 8'd3, 8'd2);
    run_sequence(150, 30);
  endtask

  task automatic test_max_poll();
    wait_all_reported();
    program_debouncer(16'hFFFF, 8'd2, 8'd3);
    run_sequence(100, 30);
  endtask

  task automatic test_frequent_pops();
    wait_all_reported();
    program_debouncer(16'd0, 8'd2, 8'd1);
    run_sequence(150, 60);
  endtask

  // Receiver stall pattern, changing style each time the 8-bit phase counter wraps.
  logic [7:0] stall_phase = '0;
  int         stall_style = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase == 8'd0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_phase[2];
    endcase
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = pending_status.pop_front();
        if (out_tdata[1:0] !== want.code || out_tdata[2] !== want.present ||
            out_tdata[3] !== want.bouncing || out_tdata[35:4] !== want.hold_ms) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected event %0d present %b debouncing %b hold %0d, got event %0d present %b debouncing %b hold %0d",
                     want.code, want.present, want.bouncing, want.hold_ms,
                     out_tdata[1:0], out_tdata[2], out_tdata[3], out_tdata[35:4]);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_special_cases();
    test_poll_interval();
    test_queue_overflow();
    test_default_settings();
    test_fast_rise_slow_fall();
    test_long_runs();
    test_threshold_drop();
    test_max_poll();
    test_frequent_pops();
    wait_all_reported();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
